[rtl/pcg_pkg.sv]
`timescale 1ns / 1ps
package pcg_pkg;

   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_BAD_RATIO  = 2'd1;
   localparam logic [1:0] ST_DECAY_ZERO = 2'd2;
   localparam logic [1:0] ST_SHIFT_LOW  = 2'd3;

   localparam int DIV_STEPS = 64;
   localparam int PROD_B_W  = 79;

   typedef struct packed {
      logic [15:0] thresh_num;
      logic [15:0] thresh_den;
      logic [15:0] apt_num;
      logic [15:0] apt_den;
      logic [15:0] upt_num;
      logic [15:0] upt_den;
      logic [31:0] decay_rate;
      logic [5:0]  decay_den_shift;
      logic [62:0] pool_size;
   } req_type;

   typedef struct packed {
      logic [63:0] coef_a;
      logic [6:0]  coef_shift;
      logic [63:0] coef_b;
      logic [1:0]  status;
   } rsp_type;

   // One checked parameter set on its way from front to back.
   typedef struct packed {
      logic [1:0]          status;
      logic [63:0]         norm_n;
      logic [63:0]         den;
      logic [5:0]          s1;
      logic [PROD_B_W-1:0] prod_b;
      logic [15:0]         thresh_den;
      logic [5:0]          dshift;
   } work_type;

endpackage

[rtl/pcg_front.sv]
`timescale 1ns / 1ps
module pcg_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pcg_pkg::req_type  req_data,
   output logic              w_valid,
   input  logic              w_ready,
   output pcg_pkg::work_type w_data
);
   import pcg_pkg::*;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] n;
      logic [31:0] p;
      logic [31:0] decay;
      logic [62:0] pool;
      logic [15:0] tn;
      logic [15:0] td;
      logic [5:0]  dshift;
   } mid_type;

   req_type     st1_ff;
   logic        v1_ff;
   mid_type     st2_ff, st2_in;
   logic        v2_ff;
   logic        adv1, adv2;
   logic        bad_ratio;
   logic [15:0] u_diff;
   logic [31:0] n_c;
   logic [63:0] d_full;
   logic [4:0]  msb;
   logic [5:0]  s1;

   assign adv2      = !v2_ff || w_ready;
   assign adv1      = !v1_ff || adv2;
   assign req_ready = adv1;
   assign w_valid   = v2_ff;

   always_comb begin
      bad_ratio = (st1_ff.thresh_num == 16'd0) || (st1_ff.thresh_den <= st1_ff.thresh_num) ||
                  (st1_ff.apt_num == 16'd0) || (st1_ff.apt_den <= st1_ff.apt_num) ||
                  (st1_ff.upt_num == 16'd0) || (st1_ff.upt_den <= st1_ff.upt_num);
      u_diff = st1_ff.upt_den - st1_ff.upt_num;
      if (bad_ratio) begin
         st2_in.status = ST_BAD_RATIO;
      end else if (st1_ff.decay_rate == 32'd0) begin
         st2_in.status = ST_DECAY_ZERO;
      end else begin
         st2_in.status = ST_OK;
      end
      st2_in.n      = 32'(st1_ff.apt_num) * 32'(u_diff);
      st2_in.p      = 32'(st1_ff.apt_den) * 32'(st1_ff.upt_num);
      st2_in.decay  = st1_ff.decay_rate;
      st2_in.pool   = st1_ff.pool_size;
      st2_in.tn     = st1_ff.thresh_num;
      st2_in.td     = st1_ff.thresh_den;
      st2_in.dshift = st1_ff.decay_den_shift;
   end

   always_comb begin
      n_c    = (st2_ff.n == 32'd0) ? 32'd1 : st2_ff.n;
      d_full = 64'(st2_ff.p) * 64'(st2_ff.decay);
      msb    = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (n_c[i]) msb = 5'(i);
      end
      s1 = 6'd63 - 6'(msb);
      w_data.status     = st2_ff.status;
      w_data.norm_n     = 64'(n_c) << s1;
      w_data.den        = (d_full == 64'd0) ? 64'd1 : d_full;
      w_data.s1         = s1;
      w_data.prod_b     = PROD_B_W'(st2_ff.pool) * PROD_B_W'(st2_ff.tn);
      w_data.thresh_den = st2_ff.td;
      w_data.dshift     = st2_ff.dshift;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req_valid;
         if (adv2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) st1_ff <= req_data;
      if (adv2) st2_ff <= st2_in;
   end

endmodule

[rtl/pcg_queue.sv]
`timescale 1ns / 1ps
module pcg_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              w_valid,
   output logic              w_ready,
   input  pcg_pkg::work_type w_data,
   output logic              r_valid,
   input  logic              r_ready,
   output pcg_pkg::work_type r_data
);
   import pcg_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   work_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign w_ready = (count_ff != CNT_W'(DEPTH));
   assign r_valid = (count_ff != '0);
   assign r_data  = mem_ff[rd_ptr_ff];
   assign push    = w_valid && w_ready;
   assign pop     = r_valid && r_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= w_data;
   end

endmodule

[rtl/pcg_back.sv]
`timescale 1ns / 1ps
module pcg_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              r_valid,
   output logic              r_ready,
   input  pcg_pkg::work_type r_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pcg_pkg::rsp_type  rsp_data
);
   import pcg_pkg::*;

   // First pass: probe quotient (only its leading-zero count is kept) and B.
   typedef struct packed {
      logic [1:0]          status;
      logic [63:0]         norm_n;
      logic [63:0]         den;
      logic [63:0]         rem;
      logic [5:0]          s1;
      logic [6:0]          s2;
      logic                seen;
      logic [PROD_B_W-1:0] prod_b;
      logic [15:0]         brem;
      logic [63:0]         bq;
      logic [15:0]         tden;
      logic [5:0]          dshift;
   } p1_type;

   // Second pass: mantissa division.
   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] den;
      logic [63:0] rem;
      logic [63:0] lo;
      logic [63:0] q;
      logic [6:0]  shift;
      logic [63:0] coef_b;
   } p2_type;

   function automatic p1_type step1(input p1_type x, input logic nbit, input logic bbit);
      logic [64:0] t;
      logic [16:0] bt;
      logic        qb;
      p1_type      y;
      y  = x;
      t  = {x.rem, nbit};
      qb = (t >= {1'b0, x.den});
      y.rem = qb ? 64'(t - {1'b0, x.den}) : t[63:0];
      if (!x.seen && !qb) y.s2 = x.s2 + 7'd1;
      y.seen = x.seen || qb;
      bt = {x.brem, bbit};
      if (bt >= {1'b0, x.tden}) begin
         y.brem = 16'(bt - {1'b0, x.tden});
         y.bq   = {x.bq[62:0], 1'b1};
      end else begin
         y.brem = bt[15:0];
         y.bq   = {x.bq[62:0], 1'b0};
      end
      return y;
   endfunction

   function automatic p2_type mid(input p1_type x);
      logic [6:0]   s;
      logic [127:0] xw;
      p2_type       y;
      s  = 7'(x.s1) + x.s2;
      xw = {64'd0, x.norm_n} << x.s2;
      y.status = x.status;
      if (x.status == ST_OK && s < 7'(x.dshift)) y.status = ST_SHIFT_LOW;
      y.den    = x.den;
      y.rem    = xw[127:64];
      y.lo     = xw[63:0];
      y.q      = 64'd0;
      y.shift  = s - 7'(x.dshift);
      y.coef_b = x.bq;
      return y;
   endfunction

   function automatic p2_type step2(input p2_type x, input logic lbit);
      logic [64:0] t;
      p2_type      y;
      y = x;
      t = {x.rem, lbit};
      if (t >= {1'b0, x.den}) begin
         y.rem = 64'(t - {1'b0, x.den});
         y.q   = {x.q[62:0], 1'b1};
      end else begin
         y.rem = t[63:0];
         y.q   = {x.q[62:0], 1'b0};
      end
      return y;
   endfunction

   p1_type              a_ff [DIV_STEPS+1];
   logic [DIV_STEPS:0]  a_v_ff;
   p2_type              c_ff [DIV_STEPS+1];
   logic [DIV_STEPS:0]  c_v_ff;
   p1_type              a0_in;
   logic                en;

   // Whole back pipeline moves as one; stall only when the last stage is held.
   assign en        = !c_v_ff[DIV_STEPS] || rsp_ready;
   assign r_ready   = en;
   assign rsp_valid = c_v_ff[DIV_STEPS];

   always_comb begin
      a0_in.status = r_data.status;
      a0_in.norm_n = r_data.norm_n;
      a0_in.den    = r_data.den;
      a0_in.rem    = 64'd0;
      a0_in.s1     = r_data.s1;
      a0_in.s2     = 7'd0;
      a0_in.seen   = 1'b0;
      a0_in.prod_b = r_data.prod_b;
      a0_in.brem   = 16'(r_data.prod_b[PROD_B_W-1:DIV_STEPS]);
      a0_in.bq     = 64'd0;
      a0_in.tden   = r_data.thresh_den;
      a0_in.dshift = r_data.dshift;
   end

   always_comb begin
      if (c_ff[DIV_STEPS].status == ST_OK) begin
         rsp_data.coef_a     = c_ff[DIV_STEPS].q;
         rsp_data.coef_shift = c_ff[DIV_STEPS].shift;
         rsp_data.coef_b     = c_ff[DIV_STEPS].coef_b;
      end else begin
         rsp_data.coef_a     = 64'd0;
         rsp_data.coef_shift = 7'd0;
         rsp_data.coef_b     = 64'd0;
      end
      rsp_data.status = c_ff[DIV_STEPS].status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= '0;
         c_v_ff <= '0;
      end else if (en) begin
         a_v_ff <= {a_v_ff[DIV_STEPS-1:0], r_valid};
         c_v_ff <= {c_v_ff[DIV_STEPS-1:0], a_v_ff[DIV_STEPS]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0] <= a0_in;
         c_ff[0] <= mid(a_ff[DIV_STEPS]);
      end
   end

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[k+1] <= step1(a_ff[k], a_ff[k].norm_n[DIV_STEPS-1-k],
                               a_ff[k].prod_b[DIV_STEPS-1-k]);
            c_ff[k+1] <= step2(c_ff[k], c_ff[k].lo[DIV_STEPS-1-k]);
         end
      end
   end

`ifndef SYNTHESIS
   a_norm_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_OK |-> rsp_data.coef_a[63])
      else $error("mantissa not normalized");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         rsp_data.coef_a == 64'd0 && rsp_data.coef_b == 64'd0 && rsp_data.coef_shift == 7'd0)
      else $error("failed check with nonzero coefficients");
   a_advance: assert property (@(posedge clock) disable iff (reset)
      en && a_v_ff[DIV_STEPS] |=> c_v_ff[0])
      else $error("item lost between division passes");
`endif

endmodule

[rtl/price_curve_coefficient_gen_top.sv]
`timescale 1ns / 1ps
// Price curve coefficient generator.
// Input channel req_valid / req_ready / req_data carries one parameter set
// per transfer; result channel rsp_valid / rsp_ready / rsp_data returns one
// result per set, in order, with coef_a, coef_shift, coef_b and status.
// Throughput: one set per cycle sustained when the receiver takes every
// result. Path from the input transfer to rsp_valid: 2 front stages, the
// queue, 64 probe-division steps, 1 normalize stage and 64 mantissa-division
// steps; each division step gives one quotient bit per stage.
// A front pipeline checks each set and forms the products; a small queue
// of QUEUE_DEPTH entries feeds the back pipeline that does the divisions.
// When the receiver holds rsp_ready low the back pipeline holds, the queue
// fills, and then req_ready drops; nothing is lost or repeated.
// Synchronous reset empties all pipelines and the queue; no item is kept
// between sets, so no clearing is needed.
module price_curve_coefficient_gen_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pcg_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pcg_pkg::rsp_type rsp_data
);
   import pcg_pkg::*;

   work_type w_data, r_data;
   logic     w_valid, w_ready, r_valid, r_ready;

   pcg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .w_valid   (w_valid),
      .w_ready   (w_ready),
      .w_data    (w_data)
   );

   pcg_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .w_valid (w_valid),
      .w_ready (w_ready),
      .w_data  (w_data),
      .r_valid (r_valid),
      .r_ready (r_ready),
      .r_data  (r_data)
   );

   pcg_back u_back (
      .clock     (clock),
      .reset     (reset),
      .r_valid   (r_valid),
      .r_ready   (r_ready),
      .r_data    (r_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

[tb/price_curve_coefficient_gen_top_test.sv]
`timescale 1ns / 1ps
module price_curve_coefficient_gen_top_test;
   import pcg_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 200;

   class coef_scoreboard;
      rsp_type coef_pending[$];
      int      mismatches = 0;

      function int lead_one(logic [63:0] v);
         int p;
         p = 0;
         for (int i = 0; i < 64; i++) if (v[i]) p = i;
         return p;
      endfunction

      function void note_set(req_type r);
         rsp_type     e;
         logic [63:0] n, d, q1;
         logic [127:0] wide;
         int          s1, s2, s;
         e = '0;
         if (r.thresh_num == 0 || r.thresh_den <= r.thresh_num ||
             r.apt_num == 0 || r.apt_den <= r.apt_num ||
             r.upt_num == 0 || r.upt_den <= r.upt_num) begin
            e.status = ST_BAD_RATIO;
         end else if (r.decay_rate == 0) begin
            e.status = ST_DECAY_ZERO;
         end else begin
            n = 64'(r.apt_num) * 64'(r.upt_den - r.upt_num);
            d = 64'(r.apt_den) * 64'(r.upt_num) * 64'(r.decay_rate);
            if (n == 0) n = 1;
            if (d == 0) d = 1;
            s1 = 63 - lead_one(n);
            q1 = (n << s1) / d;
            s2 = (q1 == 0) ? 64 : 63 - lead_one(q1);
            s = s1 + s2;
            if (s < int'(r.decay_den_shift)) begin
               e.status = ST_SHIFT_LOW;
            end else begin
               wide = {64'd0, n} << s;
               e.coef_a = 64'(wide / {64'd0, d});
               e.coef_shift = 7'(s - int'(r.decay_den_shift));
               wide = {65'd0, r.pool_size} * {112'd0, r.thresh_num};
               e.coef_b = 64'(wide / {112'd0, r.thresh_den});
               e.status = ST_OK;
            end
         end
         coef_pending.push_back(e);
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (coef_pending.size() == 0) begin
            $error("unexpected result transfer: %p", got);
            mismatches++;
            return;
         end
         e = coef_pending.pop_front();
         if (got.coef_a !== e.coef_a) begin
            $error("coef_a expected %h actual %h", e.coef_a, got.coef_a);
            mismatches++;
         end
         if (got.coef_shift !== e.coef_shift) begin
            $error("coef_shift expected %0d actual %0d", e.coef_shift, got.coef_shift);
            mismatches++;
         end
         if (got.coef_b !== e.coef_b) begin
            $error("coef_b expected %h actual %h", e.coef_b, got.coef_b);
            mismatches++;
         end
         if (got.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, got.status);
            mismatches++;
         end
      endfunction
   endclass

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;

   coef_scoreboard coef_sb = new();
   int idle_phase = 0;   // 0 none, 1 sender, 2 receiver, 3 both
   int cycle_count = 0;

   price_curve_coefficient_gen_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Check every result transfer; stall the receiver per phase.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) coef_sb.check_result(rsp_data);
      if (idle_phase == 2) rsp_ready <= ($urandom_range(99) >= 54);
      else if (idle_phase == 3) rsp_ready <= ($urandom_range(99) >= 14);
      else rsp_ready <= 1'b1;
   end

   function req_type make_set(logic [15:0] tn, logic [15:0] td, logic [15:0] an,
                              logic [15:0] ad, logic [15:0] un, logic [15:0] ud,
                              logic [31:0] dr, logic [5:0] ds, logic [62:0] pool);
      req_type r;
      r.thresh_num = tn; r.thresh_den = td;
      r.apt_num = an; r.apt_den = ad;
      r.upt_num = un; r.upt_den = ud;
      r.decay_rate = dr; r.decay_den_shift = ds; r.pool_size = pool;
      return r;
   endfunction

   function void rand_ratio(output logic [15:0] num, output logic [15:0] den);
      den = 16'($urandom_range(65535, 2));
      if ($urandom_range(3) == 0) den = 16'($urandom_range(20, 2));
      num = 16'($urandom_range(den - 1, 1));
   endfunction

   function req_type rand_set();
      req_type r;
      r = req_type'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      if ($urandom_range(9) != 0) begin
         rand_ratio(r.thresh_num, r.thresh_den);
         rand_ratio(r.apt_num, r.apt_den);
         rand_ratio(r.upt_num, r.upt_den);
         case ($urandom_range(9))
            0: r.decay_rate = 0;
            1, 2: r.decay_rate = 32'($urandom_range(255, 1));
            default: if (r.decay_rate == 0) r.decay_rate = 1;
         endcase
      end
      return r;
   endfunction

   task send_set(req_type r);
      int idle_pct;
      idle_pct = (idle_phase == 3) ? 14 : 54;
      if (idle_phase == 1 || idle_phase == 3) begin
         while ($urandom_range(99) < idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= r;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      coef_sb.note_set(r);
   endtask

   task wait_drained();
      req_valid <= 1'b0;
      while (coef_sb.coef_pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, each failing check, check order, zero probe quotient
      send_set(make_set(65534, 65535, 65534, 65535, 65534, 65535, '1, 0, '1));
      send_set(make_set(1, 65535, 1, 65535, 1, 65535, 1, 0, '1));
      send_set(make_set(1, 2, 1, 2, 1, 2, 1, 0, 0));
      send_set(make_set(0, 5, 1, 2, 1, 2, 7, 0, 100));
      send_set(make_set(5, 5, 1, 2, 1, 2, 7, 0, 100));
      send_set(make_set(6, 5, 1, 2, 1, 2, 7, 0, 100));
      send_set(make_set(1, 2, 0, 2, 1, 2, 7, 0, 100));
      send_set(make_set(1, 2, 2, 2, 1, 2, 7, 0, 100));
      send_set(make_set(1, 2, 3, 2, 1, 2, 7, 0, 100));
      send_set(make_set(1, 2, 1, 2, 0, 2, 7, 0, 100));
      send_set(make_set(1, 2, 1, 2, 2, 2, 7, 0, 100));
      send_set(make_set(1, 2, 1, 2, 3, 2, 7, 0, 100));
      send_set(make_set(1, 2, 1, 2, 1, 2, 0, 0, 100));
      send_set(make_set(0, 0, 1, 2, 1, 2, 0, 63, 100));
      send_set(make_set(1, 2, 1, 2, 1, 2, 1, 63, 100));
      send_set(make_set(1, 2, 1, 2, 1, 2, 1, 32, 100));
      send_set(make_set(1, 65535, 1, 65535, 65534, 65535, '1, 0, 12345));
      send_set(make_set(1, 65535, 1, 65535, 65534, 65535, '1, 63, 12345));
      send_set(make_set(3, 7, 1, 3, 2, 3, 1, 0, 63'h2aaa_aaaa_aaaa_aaaa));
      send_set(make_set(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_set(make_set('1, '1, '1, '1, '1, '1, '1, '1, '1));
      wait_drained();

      for (int i = 0; i < 1250; i++) begin
         idle_phase = (i / 80) % 4;
         if (i == 600) wait_drained();
         send_set(rand_set());
      end
      req_valid <= 1'b0;

      while (coef_sb.coef_pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (coef_sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

[files.f]
rtl/pcg_pkg.sv
rtl/pcg_front.sv
rtl/pcg_queue.sv
rtl/pcg_back.sv
rtl/price_curve_coefficient_gen_top.sv
tb/price_curve_coefficient_gen_top_test.sv
